// ----- sv/bss_pkg.sv -----
package bss_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_MIN_TEMP  = 2'd0;
  localparam logic [1:0] REG_MAX_TEMP  = 2'd1;
  localparam logic [1:0] REG_SEL_MONTH = 2'd2;

  localparam logic [3:0] LAST_MONTH  = 4'd12;
  localparam logic [4:0] LAST_DAY    = 5'd31;
  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;

  localparam logic signed [7:0] EMPTY_MIN = 8'sh7f;
  localparam logic signed [7:0] EMPTY_MAX = 8'sh80;

  localparam logic signed [7:0] MIN_TEMP_RESET = -8'sd99;
  localparam logic signed [7:0] MAX_TEMP_RESET = 8'sd99;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              well_formed;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic signed [7:0] temperature;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         bin_index;
    logic [23:0]        valid_rows;
    logic [23:0]        sample_count;
    logic signed [31:0] sample_total;
    logic signed [7:0]  sample_min;
    logic signed [7:0]  sample_max;
    logic [23:0]        error_rows;
  } result_t;

  typedef struct packed {
    logic signed [7:0] min_temp;
    logic signed [7:0] max_temp;
    logic [3:0]        sel_month;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

// ----- sv/bss_ctrl.sv -----
module bss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  output bss_pkg::cmd_t cmd
);
  import bss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && item_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.load_out = (state == S_REPORT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // raise the result on a load and drop it once the downstream side takes it
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/bss_datapath.sv -----
module bss_datapath #(
  parameter int NUM_BINS   = 13,
  parameter int COUNT_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  bss_pkg::cmd_t    cmd,
  input  bss_pkg::cfg_t    cfg,
  input  bss_pkg::item_t   item,
  output bss_pkg::result_t result
);
  import bss_pkg::*;

  localparam int BinW = $clog2(NUM_BINS);

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t CountMax = '1;

  function automatic count_t sat_inc(input count_t c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  item_t             cur;
  logic              acc;
  count_t            rej;
  count_t            rows [NUM_BINS];
  count_t            cnt  [NUM_BINS];
  logic signed [31:0] tot [NUM_BINS];
  logic signed [7:0] lo   [NUM_BINS];
  logic signed [7:0] hi   [NUM_BINS];

  logic [BinW-1:0]   idx;
  logic              in_range;
  logic              valid_rec;
  logic              take;
  logic              filt;
  logic              add_m;
  logic              add_0;
  logic signed [31:0] temp_ext;
  result_t           next_result;

  assign idx       = cur.month[BinW-1:0];
  assign in_range  = {1'b0, cur.month} < 5'(NUM_BINS);
  assign temp_ext  = 32'(cur.temperature);

  assign valid_rec = cur.well_formed
                  && (cur.month >= 4'd1) && (cur.month <= LAST_MONTH)
                  && (cur.day >= 5'd1) && (cur.day <= LAST_DAY)
                  && (cur.hour <= LAST_HOUR)
                  && (cur.minute <= LAST_MINUTE)
                  && (cur.temperature >= cfg.min_temp)
                  && (cur.temperature <= cfg.max_temp);
  assign take      = valid_rec && in_range;
  assign filt      = (cfg.sel_month == 4'd0) || (cfg.sel_month == cur.month);
  // a saturated bin ignores further samples
  assign add_m     = filt && (cnt[idx] != CountMax);
  assign add_0     = filt && (cnt[0] != CountMax);

  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= item;
    if (cmd.exec) acc <= (cur.opcode == OP_ADD) && take;

    if (rst || (cmd.exec && (cur.opcode == OP_CLEAR))) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        rows[i] <= '0;
        cnt[i]  <= '0;
        tot[i]  <= '0;
        lo[i]   <= EMPTY_MIN;
        hi[i]   <= EMPTY_MAX;
      end
      rej <= '0;
    end else if (cmd.exec && (cur.opcode == OP_ADD)) begin
      if (take) begin
        // month bin is never bin 0 here, so the two writes never collide
        rows[idx] <= sat_inc(rows[idx]);
        rows[0]   <= sat_inc(rows[0]);
        if (add_m) begin
          cnt[idx] <= cnt[idx] + 1'b1;
          tot[idx] <= tot[idx] + temp_ext;
          if (cur.temperature < lo[idx]) lo[idx] <= cur.temperature;
          if (cur.temperature > hi[idx]) hi[idx] <= cur.temperature;
        end
        if (add_0) begin
          cnt[0] <= cnt[0] + 1'b1;
          tot[0] <= tot[0] + temp_ext;
          if (cur.temperature < lo[0]) lo[0] <= cur.temperature;
          if (cur.temperature > hi[0]) hi[0] <= cur.temperature;
        end
      end else begin
        rej <= sat_inc(rej);
      end
    end

    if (cmd.load_out) result <= next_result;
  end

  always_comb begin
    next_result            = '0;
    next_result.accepted   = acc;
    next_result.bin_index  = cur.month;
    next_result.error_rows = 24'(rej);
    if (in_range) begin
      next_result.valid_rows   = 24'(rows[idx]);
      next_result.sample_count = 24'(cnt[idx]);
      next_result.sample_total = tot[idx];
      next_result.sample_min   = lo[idx];
      next_result.sample_max   = hi[idx];
    end else begin
      next_result.sample_min   = EMPTY_MIN;
      next_result.sample_max   = EMPTY_MAX;
    end
  end

endmodule

// ----- sv/binned_sample_statistics.sv -----
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    bss_pkg::item_t
// result    out        result_valid / result_stall bss_pkg::result_t
// config    in         APB psel/penable/pwrite    3 registers at 0x0, 0x4, 0x8
//
// Each item passes through three steps: capture, update of the month bin and
// bin 0, and load of the result register after the update.
// The statistics registers are flip-flops; reset and a clear operation set
// them to the empty values.
// A new item is taken while an earlier result still waits in the result
// register; a stalled result holds the block in its report step.
module binned_sample_statistics #(
  parameter int NUM_BINS   = 13,
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  bss_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bss_pkg::result_t                result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bss_pkg::PADDR_W-1:0]     paddr,
  input  logic [bss_pkg::PDATA_W-1:0]     pwdata,
  output logic [bss_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import bss_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_temp  <= MIN_TEMP_RESET;
      cfg.max_temp  <= MAX_TEMP_RESET;
      cfg.sel_month <= 4'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MIN_TEMP:  cfg.min_temp  <= pwdata[7:0];
        REG_MAX_TEMP:  cfg.max_temp  <= pwdata[7:0];
        REG_SEL_MONTH: cfg.sel_month <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_TEMP:  prdata = {24'd0, cfg.min_temp};
      REG_MAX_TEMP:  prdata = {24'd0, cfg.max_temp};
      REG_SEL_MONTH: prdata = {28'd0, cfg.sel_month};
      default:       prdata = '0;
    endcase
  end

  bss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  bss_datapath #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  // the block is busy for the cycle after taking a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item channel open right after a transfer");

  // an accepted record always leaves a nonzero valid-row count in its bin
  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.accepted |-> result.valid_rows != 24'd0)
    else $error("accepted record with zero valid rows");

  // bins outside the table report as empty
  a_empty_bin: assert property (@(posedge clk) disable iff (rst)
    result_valid && ({1'b0, result.bin_index} >= 5'(NUM_BINS))
      |-> result.sample_count == 24'd0 && result.valid_rows == 24'd0
          && !result.accepted)
    else $error("bin outside the table reports data");

endmodule
